>>> hdl/crcfd_pkg.sv
// crcfd_pkg: types, constants and the CRC-32 byte step shared by the deframer.
// No dependencies.
`timescale 1ns / 1ps

package crcfd_pkg;

	localparam int HEADER_BYTES = 18;
	localparam int CRC_SPAN     = 14;
	localparam int POS_W        = 11;
	localparam int QUEUE_DEPTH  = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 11;

	localparam logic [15:0] MAX_PAYLOAD = 16'd1024;
	localparam logic [15:0] LIMIT_CAP   = 16'((2 ** POS_W) - 1 - HEADER_BYTES);

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h57, 8'h52, 8'h50};

	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT    = 2'd1;

	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_RESYNC = 1'b1;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_VERDICT = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_CRC_BAD     = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_FLAGS_SET   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG    = 3'd4;

	// results of one item: optional payload byte, then optional verdict/reject
	typedef struct packed {
		logic        has_pay;
		logic        has_fin;
		kind_t       fin_kind;
		logic [7:0]  pay_byte;
		logic [7:0]  ftype;
		logic [31:0] seq;
		logic [15:0] len;
		logic [2:0]  status;
		logic [31:0] err;
		logic [31:0] acc;
	} rec_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] v;
		v = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage

>>> hdl/crcfd_front.sv
// crcfd_front: accepts stream bytes, tracks the frame, checks header and CRC,
// and emits one record per item that gives results. Depends on crcfd_pkg.
`timescale 1ns / 1ps

module crcfd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic                              op,
	input  logic [7:0]                        data_byte,
	input  logic                              cfg_wr,
	input  logic [crcfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crcfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                              rec_vld,
	output crcfd_pkg::rec_t                   rec
);
	import crcfd_pkg::*;

	logic [7:0]       pver_q;
	logic [10:0]      plim_q;
	logic [POS_W-1:0] pos_q, pos_d, pos_n;
	logic [31:0]      crc_q, crc_d, crc_b, crc_m;
	logic [7:0]       hver_q, hver_d, htype_q, htype_d;
	logic [15:0]      hflags_q, hflags_d, hlen_q, hlen_d;
	logic [31:0]      hseq_q, hseq_d, rcrc_q, rcrc_d;
	logic [31:0]      err_q, err_d, acc_q, acc_d;
	logic [15:0]      lim;
	logic [16:0]      end_pos;
	logic             do_verdict;

	assign crc_b   = crc_byte(crc_q, data_byte);
	assign crc_m   = crc_byte(CRC_ONES, data_byte);
	assign pos_n   = pos_q + 1'b1;
	assign end_pos = 17'(HEADER_BYTES) + {1'b0, hlen_q};

	always_comb begin
		lim = {5'd0, plim_q};
		if (lim > MAX_PAYLOAD) lim = MAX_PAYLOAD;
		if (lim > LIMIT_CAP) lim = LIMIT_CAP;
	end

	always_comb begin
		pos_d      = pos_q;
		crc_d      = crc_q;
		hver_d     = hver_q;
		htype_d    = htype_q;
		hflags_d   = hflags_q;
		hseq_d     = hseq_q;
		hlen_d     = hlen_q;
		rcrc_d     = rcrc_q;
		err_d      = err_q;
		acc_d      = acc_q;
		rec_vld    = 1'b0;
		rec        = '0;
		do_verdict = 1'b0;
		if (take) begin
			if (op == OP_RESYNC) begin
				pos_d = '0;
				crc_d = CRC_ONES;
			end else if (pos_q == '0 || (pos_q < POS_W'(4) && data_byte != MAGIC[pos_q[1:0]])) begin
				if (pos_q != '0) err_d = err_q + 1'b1;
				if (data_byte == MAGIC[0]) begin
					pos_d = POS_W'(1);
					crc_d = crc_m;
				end else begin
					pos_d = '0;
					crc_d = CRC_ONES;
				end
			end else if (pos_q < POS_W'(4)) begin
				crc_d = crc_b;
				pos_d = pos_n;
			end else if (pos_q < POS_W'(HEADER_BYTES)) begin
				if (pos_q < POS_W'(CRC_SPAN)) crc_d = crc_b;
				case (pos_q[4:0])
					5'd4:    hver_d          = data_byte;
					5'd5:    htype_d         = data_byte;
					5'd6:    hflags_d[7:0]   = data_byte;
					5'd7:    hflags_d[15:8]  = data_byte;
					5'd8:    hseq_d[7:0]     = data_byte;
					5'd9:    hseq_d[15:8]    = data_byte;
					5'd10:   hseq_d[23:16]   = data_byte;
					5'd11:   hseq_d[31:24]   = data_byte;
					5'd12:   hlen_d[7:0]     = data_byte;
					5'd13:   hlen_d[15:8]    = data_byte;
					5'd14:   rcrc_d[7:0]     = data_byte;
					5'd15:   rcrc_d[15:8]    = data_byte;
					5'd16:   rcrc_d[23:16]   = data_byte;
					default: rcrc_d[31:24]   = data_byte;
				endcase
				pos_d = pos_n;
				if (pos_n == POS_W'(HEADER_BYTES)) begin
					if (hver_d != pver_q) rec.status = ST_BAD_VERSION;
					else if (hflags_d != 16'd0) rec.status = ST_FLAGS_SET;
					else if (hlen_d > lim) rec.status = ST_TOO_LONG;
					if (rec.status != ST_OK) begin
						err_d        = err_q + 1'b1;
						rec_vld      = 1'b1;
						rec.has_fin  = 1'b1;
						rec.fin_kind = KIND_REJECT;
						pos_d        = '0;
						crc_d        = CRC_ONES;
					end else if (hlen_d == 16'd0) begin
						do_verdict = 1'b1;
					end
				end
			end else begin
				crc_d        = crc_b;
				rec_vld      = 1'b1;
				rec.has_pay  = 1'b1;
				rec.pay_byte = data_byte;
				pos_d        = pos_n;
				if ({6'd0, pos_n} >= end_pos) do_verdict = 1'b1;
			end
			if (do_verdict) begin
				rec_vld      = 1'b1;
				rec.has_fin  = 1'b1;
				rec.fin_kind = KIND_VERDICT;
				if ((crc_d ^ CRC_ONES) == rcrc_d) begin
					acc_d      = acc_q + 1'b1;
					rec.status = ST_OK;
				end else begin
					err_d      = err_q + 1'b1;
					rec.status = ST_CRC_BAD;
				end
				pos_d = '0;
				crc_d = CRC_ONES;
			end
		end
		rec.ftype = htype_d;
		rec.seq   = hseq_d;
		rec.len   = hlen_d;
		rec.err   = err_d;
		rec.acc   = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pver_q <= 8'd1;
			plim_q <= 11'd1024;
			pos_q  <= '0;
			crc_q  <= CRC_ONES;
			err_q  <= '0;
			acc_q  <= '0;
		end else begin
			if (cfg_wr && cfg_index == REG_PROTOCOL_VERSION) pver_q <= cfg_data[7:0];
			if (cfg_wr && cfg_index == REG_PAYLOAD_LIMIT) plim_q <= cfg_data[10:0];
			pos_q <= pos_d;
			crc_q <= crc_d;
			err_q <= err_d;
			acc_q <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		hver_q   <= hver_d;
		htype_q  <= htype_d;
		hflags_q <= hflags_d;
		hseq_q   <= hseq_d;
		hlen_q   <= hlen_d;
		rcrc_q   <= rcrc_d;
	end

endmodule

>>> hdl/crcfd_queue.sv
// crcfd_queue: short record queue between front and back.
// Depends on crcfd_pkg.
`timescale 1ns / 1ps

module crcfd_queue #(
	parameter int DEPTH = crcfd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  crcfd_pkg::rec_t wr_rec,
	input  logic            rd,
	output crcfd_pkg::rec_t rd_rec,
	output logic            has_data,
	output logic            is_full
);
	import crcfd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign has_data = (cnt_q != '0);
	assign is_full  = (cnt_q == CW'(DEPTH));
	assign rd_rec   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hdl/crcfd_back.sv
// crcfd_back: output register; splits each record into its results.
// Depends on crcfd_pkg.
`timescale 1ns / 1ps

module crcfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_has,
	input  crcfd_pkg::rec_t q_rec,
	output logic            q_rd,
	input  logic            pop,
	output logic            empty,
	output logic [1:0]      kind,
	output logic [7:0]      payload_byte,
	output logic [7:0]      frame_type,
	output logic [31:0]     sequence_res,
	output logic [15:0]     length_field,
	output logic [2:0]      status,
	output logic [31:0]     error_total,
	output logic [31:0]     accepted_total,
	output logic            last_of_run
);
	import crcfd_pkg::*;

	rec_t rec_q;
	logic vld_q, second_q;
	logic on_pay, pair, done;

	assign on_pay = rec_q.has_pay && !second_q;
	assign pair   = rec_q.has_pay && rec_q.has_fin;
	assign done   = pop && vld_q && !(pair && !second_q);
	assign q_rd   = q_has && (!vld_q || done);

	assign empty          = !vld_q;
	assign kind           = on_pay ? KIND_PAYLOAD : rec_q.fin_kind;
	assign payload_byte   = on_pay ? rec_q.pay_byte : 8'd0;
	assign status         = on_pay ? ST_OK : rec_q.status;
	assign last_of_run    = !(on_pay && rec_q.has_fin);
	assign frame_type     = rec_q.ftype;
	assign sequence_res   = rec_q.seq;
	assign length_field   = rec_q.len;
	assign error_total    = rec_q.err;
	assign accepted_total = rec_q.acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= 1'b0;
			second_q <= 1'b0;
		end else if (q_rd) begin
			vld_q    <= 1'b1;
			second_q <= 1'b0;
		end else if (done) begin
			vld_q    <= 1'b0;
			second_q <= 1'b0;
		end else if (pop && vld_q) begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) rec_q <= q_rec;
	end

endmodule

>>> hdl/crc32_frame_deframer_core.sv
// crc32_frame_deframer_core: top level of the CRC-32 checked frame deframer.
// Depends on crcfd_pkg, crcfd_front, crcfd_queue, crcfd_back.
`timescale 1ns / 1ps

// One byte item is taken per clock whenever full is low; the front parser
// handles it in that cycle with a byte-wide CRC-32 step and a position
// counter. An item gives zero, one or two results (the last payload byte
// gives the byte and the verdict). Results leave at one per clock through
// an output register fed by a QUEUE_DEPTH-entry record queue, so full only
// rises when the consumer stalls or pairs of results pile up. The header
// fields and counters on the result ports belong to the frame and the item
// that caused the result. Configuration writes are always ready.
module crc32_frame_deframer_core #(
	parameter int QUEUE_DEPTH = crcfd_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              op,
	input  logic [7:0]                        data_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        kind,
	output logic [7:0]                        payload_byte,
	output logic [7:0]                        frame_type,
	output logic [31:0]                       sequence_res,
	output logic [15:0]                       length_field,
	output logic [2:0]                        status,
	output logic [31:0]                       error_total,
	output logic [31:0]                       accepted_total,
	output logic                              last_of_run,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [crcfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crcfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import crcfd_pkg::*;

	logic take, rec_vld, q_rd, q_has, q_full;
	rec_t rec, q_rec;

	assign full      = q_full;
	assign take      = push && !q_full;
	assign cfg_ready = 1'b1;

	crcfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (op),
		.data_byte (data_byte),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec_vld   (rec_vld),
		.rec       (rec)
	);

	crcfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (rec_vld),
		.wr_rec   (rec),
		.rd       (q_rd),
		.rd_rec   (q_rec),
		.has_data (q_has),
		.is_full  (q_full)
	);

	crcfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_has          (q_has),
		.q_rec          (q_rec),
		.q_rd           (q_rd),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.frame_type     (frame_type),
		.sequence_res   (sequence_res),
		.length_field   (length_field),
		.status         (status),
		.error_total    (error_total),
		.accepted_total (accepted_total),
		.last_of_run    (last_of_run)
	);

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rec_vld |-> !q_full)
		else $error("record written into a full queue");

	a_only_payload_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_of_run) |-> (kind == KIND_PAYLOAD))
		else $error("non-last result is not a payload byte");

	a_verdict_follows_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_of_run) |=> (!empty && kind == KIND_VERDICT && last_of_run))
		else $error("verdict missing after last payload byte");

endmodule

>>> verif/crc32_frame_deframer_core_tb.sv
// crc32_frame_deframer_core_tb: self-checking bench for the CRC-32 frame deframer core.
// Drives byte items and config writes with random idling and checks every result.
// Depends on crcfd_pkg and crc32_frame_deframer_core.
`timescale 1ns / 1ps

module crc32_frame_deframer_core_tb;

	import crcfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 330;
	localparam int DIR_ROWS     = 25;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pay;
		logic [7:0]  ftype;
		logic [31:0] seq;
		logic [15:0] len;
		logic [2:0]  st;
		logic [31:0] err;
		logic [31:0] acc;
		logic        last;
	} frame_res_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  data;
		logic        typed;
		kind_t       t_kind;
		logic [2:0]  t_status;
		logic [31:0] t_err;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic op = OP_BYTE;
	logic [7:0] data_byte = 8'h00;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [7:0] frame_type;
	logic [31:0] sequence_res;
	logic [15:0] length_field;
	logic [2:0] status;
	logic [31:0] error_total;
	logic [31:0] accepted_total;
	logic last_of_run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PROTOCOL_VERSION;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	always #10 clk = ~clk;

	crc32_frame_deframer_core uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .op(op), .data_byte(data_byte),
		.empty(empty), .pop(pop),
		.kind(kind), .payload_byte(payload_byte), .frame_type(frame_type),
		.sequence_res(sequence_res), .length_field(length_field), .status(status),
		.error_total(error_total), .accepted_total(accepted_total),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// deframer shadow state
	logic [7:0]  cfg_ver = 8'd1;
	logic [10:0] cfg_lim = 11'd1024;
	logic [10:0] rx_pos = '0;
	logic [31:0] rx_crc = CRC_ONES;
	logic [7:0]  hdr_ver = '0;
	logic [7:0]  hdr_type = '0;
	logic [15:0] hdr_flags = '0;
	logic [31:0] hdr_seq = '0;
	logic [15:0] hdr_len = '0;
	logic [31:0] hdr_crc = '0;
	logic [31:0] err_cnt = '0;
	logic [31:0] acc_cnt = '0;

	frame_res_t pending_res [$];
	stim_t      feed_q [$];
	stim_t      cur_item;
	frame_res_t got_want;
	int fails = 0;
	int made;
	int queued_items = 0;
	int feed_hold = 0, feed_pct = 0, feed_run = 0;
	int drain_hold = 0, drain_pct = 0, drain_run = 0;

	stim_t dir_rows [DIR_ROWS] = '{
		'{OP_RESYNC, 8'h00, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h00, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h4D, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h4D, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h57, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h58, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h4D, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h57, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h52, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h50, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h00, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'hFF, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h00, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h00, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h00, 1'b0, KIND_PAYLOAD, ST_OK, 32'd0},
		'{OP_BYTE,   8'h00, 1'b1, KIND_REJECT,  ST_BAD_VERSION, 32'd3}
	};

	function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] v;
		v = c ^ {24'd0, b};
		repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		return v;
	endfunction

	function automatic int lim_now();
		int l;
		l = cfg_lim;
		if (l > MAX_PAYLOAD) l = MAX_PAYLOAD;
		if (l > LIMIT_CAP) l = LIMIT_CAP;
		return l;
	endfunction

	function automatic void hunt_restart(input logic [7:0] b);
		if (b == MAGIC[0]) begin
			rx_pos = 11'd1;
			rx_crc = crc8(CRC_ONES, b);
			hdr_ver = '0;
			hdr_type = '0;
			hdr_flags = '0;
			hdr_seq = '0;
			hdr_len = '0;
			hdr_crc = '0;
		end else begin
			rx_pos = '0;
			rx_crc = CRC_ONES;
		end
	endfunction

	function automatic frame_res_t shape_res(input kind_t k, input logic [7:0] pb,
			input logic [2:0] st);
		frame_res_t r;
		r = '0;
		r.kind = k;
		r.pay = pb;
		r.ftype = hdr_type;
		r.seq = hdr_seq;
		r.len = hdr_len;
		r.st = st;
		return r;
	endfunction

	function automatic frame_res_t close_frame();
		logic [2:0] st;
		if ((rx_crc ^ CRC_ONES) == hdr_crc) begin
			acc_cnt++;
			st = ST_OK;
		end else begin
			err_cnt++;
			st = ST_CRC_BAD;
		end
		rx_pos = '0;
		rx_crc = CRC_ONES;
		return shape_res(KIND_VERDICT, 8'h00, st);
	endfunction

	// advances the shadow deframer by one item, queues its results
	function automatic int deframe_byte(input logic o, input logic [7:0] b);
		frame_res_t r [2];
		int n, p;
		logic [2:0] st;
		n = 0;
		p = rx_pos;
		if (o == OP_RESYNC) begin
			rx_pos = '0;
			rx_crc = CRC_ONES;
			return 0;
		end
		if (p == 0) begin
			hunt_restart(b);
		end else if (p < 4) begin
			if (b != MAGIC[p]) begin
				err_cnt++;
				hunt_restart(b);
			end else begin
				rx_crc = crc8(rx_crc, b);
				rx_pos = 11'(p + 1);
			end
		end else if (p < HEADER_BYTES) begin
			if (p < CRC_SPAN) rx_crc = crc8(rx_crc, b);
			if (p == 4) hdr_ver = b;
			else if (p == 5) hdr_type = b;
			else if (p < 8) hdr_flags[(p - 6) * 8 +: 8] = b;
			else if (p < 12) hdr_seq[(p - 8) * 8 +: 8] = b;
			else if (p < 14) hdr_len[(p - 12) * 8 +: 8] = b;
			else hdr_crc[(p - 14) * 8 +: 8] = b;
			p++;
			rx_pos = 11'(p);
			if (p == HEADER_BYTES) begin
				st = ST_OK;
				if (hdr_ver != cfg_ver) st = ST_BAD_VERSION;
				else if (hdr_flags != 16'd0) st = ST_FLAGS_SET;
				else if (int'(hdr_len) > lim_now()) st = ST_TOO_LONG;
				if (st != ST_OK) begin
					err_cnt++;
					r[n] = shape_res(KIND_REJECT, 8'h00, st);
					n++;
					rx_pos = '0;
					rx_crc = CRC_ONES;
				end else if (hdr_len == 16'd0) begin
					r[n] = close_frame();
					n++;
				end
			end
		end else begin
			rx_crc = crc8(rx_crc, b);
			r[n] = shape_res(KIND_PAYLOAD, b, ST_OK);
			n++;
			p++;
			rx_pos = 11'(p);
			if (p >= HEADER_BYTES + int'(hdr_len)) begin
				r[n] = close_frame();
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			r[i].err = err_cnt;
			r[i].acc = acc_cnt;
			r[i].last = (i == n - 1);
			pending_res.push_back(r[i]);
		end
		return n;
	endfunction

	task automatic note_mismatch(input string msg);
		fails++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_pct();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 0;
		if (r < 75) return 15;
		return 50;
	endfunction

	function automatic int pick_len(input int lim);
		int r, n;
		r = $urandom_range(0, 99);
		if (r < 50) n = $urandom_range(0, 3);
		else if (r < 85) n = $urandom_range(4, 12);
		else if (r < 98) n = $urandom_range(13, 48);
		else n = lim;
		if (n > lim) n = lim;
		return n;
	endfunction

	task automatic feed_byte(input logic o, input logic [7:0] b);
		stim_t s;
		s = '0;
		s.op = o;
		s.data = b;
		feed_q.push_back(s);
	endtask

	// one frame, well formed or broken in one of several ways, plus inter-frame noise
	task automatic queue_frame();
		logic [7:0] hb [18];
		logic [7:0] fb [$];
		logic [31:0] c, s;
		logic [15:0] f;
		int sel, len, lim, cut, k;
		bit body;
		lim = lim_now();
		sel = $urandom_range(0, 99);
		k = $urandom_range(0, 99);
		if (k < 15) begin
			repeat ($urandom_range(1, 4)) feed_byte(OP_BYTE, 8'($urandom_range(0, 255)));
		end else if (k < 20) begin
			feed_byte(OP_RESYNC, 8'($urandom_range(0, 255)));
		end
		len = pick_len(lim);
		body = 1'b1;
		for (int i = 0; i < 4; i++) hb[i] = MAGIC[i];
		hb[4] = cfg_ver;
		hb[5] = 8'($urandom_range(0, 255));
		hb[6] = 8'h00;
		hb[7] = 8'h00;
		s = $urandom();
		for (int i = 0; i < 4; i++) hb[8 + i] = s[8 * i +: 8];
		if (sel >= 80 && sel < 85) begin
			len = ($urandom_range(0, 1) != 0) ? lim + 1 : $urandom_range(lim + 1, 65535);
			body = 1'b0;
		end
		hb[12] = len[7:0];
		hb[13] = len[15:8];
		c = CRC_ONES;
		for (int i = 0; i < CRC_SPAN; i++) c = crc8(c, hb[i]);
		for (int i = 0; i < 18; i++) fb.push_back(hb[i]);
		if (body) begin
			for (int i = 0; i < len; i++) begin
				fb.push_back(8'($urandom_range(0, 255)));
				c = crc8(c, fb[18 + i]);
			end
		end
		c = c ^ CRC_ONES;
		for (int i = 0; i < 4; i++) fb[14 + i] = c[8 * i +: 8];
		if (sel >= 60 && sel < 70) begin
			k = $urandom_range(14, 17);
			fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
		end else if (sel >= 70 && sel < 75) begin
			fb[4] = cfg_ver ^ 8'($urandom_range(1, 255));
			if ($urandom_range(0, 1) != 0) fb[6] = 8'($urandom_range(1, 255));
			fb = fb[0:17];
		end else if (sel >= 75 && sel < 80) begin
			f = ($urandom_range(0, 1) != 0) ? (16'h0001 << $urandom_range(0, 15))
				: 16'($urandom_range(1, 65535));
			fb[6] = f[7:0];
			fb[7] = f[15:8];
			if ($urandom_range(0, 1) != 0) begin
				fb[12] = 8'hFF;
				fb[13] = 8'hFF;
			end
			fb = fb[0:17];
		end else if (sel >= 90 && sel < 95) begin
			cut = $urandom_range(1, fb.size() - 1);
			fb = fb[0:cut - 1];
		end else if (sel >= 95) begin
			// broken magic ahead of a good frame
			k = $urandom_range(1, 3);
			for (int i = k - 1; i >= 0; i--) fb.push_front(MAGIC[i]);
		end
		foreach (fb[i]) feed_byte(OP_BYTE, fb[i]);
		queued_items += fb.size();
		if (sel >= 90 && sel < 95 && $urandom_range(0, 9) < 7)
			feed_byte(OP_RESYNC, 8'($urandom_range(0, 255)));
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_PROTOCOL_VERSION) cfg_ver = val[7:0];
		else if (idx == REG_PAYLOAD_LIMIT) cfg_lim = val;
		@(posedge clk);
	endtask

	task automatic wait_quiet();
		while (feed_q.size() != 0 || push || pending_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// item side
	always @(posedge clk) begin
		if (push && !full) begin
			made = deframe_byte(cur_item.op, cur_item.data);
			if (cur_item.typed) begin
				if (made == 0) begin
					note_mismatch("directed row predicted no result");
				end else begin
					pending_res[pending_res.size() - 1].kind = cur_item.t_kind;
					pending_res[pending_res.size() - 1].st = cur_item.t_status;
					pending_res[pending_res.size() - 1].err = cur_item.t_err;
				end
			end
		end
		if (!push || !full) begin
			if (feed_hold > 0) begin
				feed_hold--;
				push <= 1'b0;
			end else if (arst_n && feed_q.size() != 0 && $urandom_range(0, 99) < feed_pct) begin
				feed_hold = pick_gap() - 1;
				push <= 1'b0;
			end else if (arst_n && feed_q.size() != 0) begin
				cur_item = feed_q.pop_front();
				push <= 1'b1;
				op <= cur_item.op;
				data_byte <= cur_item.data;
			end else begin
				push <= 1'b0;
			end
		end
		if (feed_run == 0) begin
			feed_pct = pick_pct();
			feed_run = $urandom_range(30, 300);
		end else begin
			feed_run--;
		end
	end

	// result side
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_res.size() == 0) begin
				note_mismatch($sformatf("unexpected result kind %0d", kind));
			end else begin
				got_want = pending_res.pop_front();
				cmp_field("kind", 32'(kind), 32'(got_want.kind));
				cmp_field("payload_byte", 32'(payload_byte), 32'(got_want.pay));
				cmp_field("frame_type", 32'(frame_type), 32'(got_want.ftype));
				cmp_field("sequence_res", sequence_res, got_want.seq);
				cmp_field("length_field", 32'(length_field), 32'(got_want.len));
				cmp_field("status", 32'(status), 32'(got_want.st));
				cmp_field("error_total", error_total, got_want.err);
				cmp_field("accepted_total", accepted_total, got_want.acc);
				cmp_field("last_of_run", 32'(last_of_run), 32'(got_want.last));
			end
		end
		if (drain_hold > 0) begin
			drain_hold--;
			pop <= 1'b0;
		end else if ($urandom_range(0, 99) < drain_pct) begin
			drain_hold = pick_gap() - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
		if (drain_run == 0) begin
			drain_pct = pick_pct();
			drain_run = $urandom_range(30, 300);
		end else begin
			drain_run--;
		end
	end

	initial begin
		int guard;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) feed_q.push_back(dir_rows[i]);
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_quiet();
				case (ph)
					1: begin
						set_reg(REG_PROTOCOL_VERSION, 11'h7FF);
						set_reg(REG_PAYLOAD_LIMIT, 11'd0);
						set_reg(REG_UNUSED_LO, 11'($urandom_range(0, 2047)));
						set_reg(REG_UNUSED_HI, 11'h7FF);
					end
					2: begin
						set_reg(REG_PROTOCOL_VERSION, 11'd0);
						set_reg(REG_PAYLOAD_LIMIT, 11'h7FF);
						set_reg(REG_UNUSED_HI, 11'd0);
					end
					3: begin
						set_reg(REG_PROTOCOL_VERSION, 11'($urandom_range(0, 2047)));
						set_reg(REG_PAYLOAD_LIMIT, 11'd1);
					end
					4: begin
						set_reg(REG_PROTOCOL_VERSION, 11'd1);
						set_reg(REG_PAYLOAD_LIMIT, 11'd1024);
					end
					default: begin
						set_reg(REG_PROTOCOL_VERSION, 11'($urandom_range(0, 2047)));
						set_reg(REG_PAYLOAD_LIMIT, 11'($urandom_range(2, 80)));
					end
				endcase
			end
			queued_items = 0;
			while (queued_items < PHASE_ITEMS) queue_frame();
		end
		for (guard = 0; guard < 200000 &&
				(feed_q.size() != 0 || push || pending_res.size() != 0); guard++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_res.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_res.size()));
		if (fails == 0) begin
			$display("crc32_frame_deframer_core_tb: clean");
		end else begin
			$display("crc32_frame_deframer_core_tb: errors");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("crc32_frame_deframer_core_tb: errors");
		$finish;
	end

endmodule
